// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the matrix unit RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside of reset
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed: %m");

// property checked on every clock edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: %m");

`endif

// ----- src/matx_pkg.sv -----
// ----------------------------------------------------------------------------
// matx_pkg
// Shared constants, codes and control bundles of the matrix unit.
// ----------------------------------------------------------------------------
`default_nettype none

package matx_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAT_DIM   = 4;
    localparam int NELEM     = MAT_DIM * MAT_DIM;
    localparam int IDX_W     = $clog2(NELEM);
    localparam int DIM_W     = (MAT_DIM > 1) ? $clog2(MAT_DIM) : 1;
    localparam int ACC_W     = 64 + $clog2(MAT_DIM);
    localparam int VAL_W     = 32;
    localparam int OIDX_W    = 4;
    localparam int CMD_W     = 3;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_LEFT  = 3'd0,
        CMD_LOAD_RIGHT = 3'd1,
        CMD_MUL        = 3'd2,
        CMD_ADD        = 3'd3,
        CMD_SUB        = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_EMIT
    } state_t;

    // matrix store port controls
    typedef struct packed {
        logic rd_en;
        logic ld_left;
        logic ld_right;
        logic res_we;
        logic swap;
    } st_ctl_t;

    // tags that travel with an operand pair into the mac
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

endpackage

`default_nettype wire

// ----- src/matx_store.sv -----
// ----------------------------------------------------------------------------
// matx_store
// Left and right matrix memories with registered reads. The left matrix
// lives in two banks: an operation reads the current bank and writes its
// results into the other one, which becomes current after the last element.
// ----------------------------------------------------------------------------
`default_nettype none

module matx_store (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire matx_pkg::st_ctl_t                   ctl,
    input  wire logic [matx_pkg::IDX_W-1:0]          left_rd_idx,
    input  wire logic [matx_pkg::IDX_W-1:0]          right_rd_idx,
    input  wire logic [matx_pkg::IDX_W-1:0]          ld_idx,
    input  wire logic signed [matx_pkg::VAL_W-1:0]   ld_data,
    input  wire logic [matx_pkg::IDX_W-1:0]          res_idx,
    input  wire logic signed [matx_pkg::VAL_W-1:0]   res_data,
    output logic signed [matx_pkg::VAL_W-1:0]        left_rd_data,
    output logic signed [matx_pkg::VAL_W-1:0]        right_rd_data
);

    localparam int LADDR_W = matx_pkg::IDX_W + 1;
    localparam int LDEPTH  = 2 * matx_pkg::NELEM;

    logic [matx_pkg::VAL_W-1:0] left_mem  [LDEPTH];
    logic [matx_pkg::VAL_W-1:0] right_mem [matx_pkg::NELEM];

    // per-entry valid flags stand in for clearing the memories at reset
    logic [LDEPTH-1:0]          left_vld_reg;
    logic [matx_pkg::NELEM-1:0] right_vld_reg;
    logic                       bank_reg;

    logic [matx_pkg::VAL_W-1:0] left_q_reg;
    logic [matx_pkg::VAL_W-1:0] right_q_reg;
    logic                       left_qv_reg;
    logic                       right_qv_reg;

    logic [LADDR_W-1:0]         left_wr_addr;
    logic [matx_pkg::VAL_W-1:0] left_wr_data;
    logic                       left_we;
    logic [LADDR_W-1:0]         left_rd_addr;

    // loads go to the current bank, results to the other one
    always_comb begin
        left_we      = ctl.ld_left | ctl.res_we;
        left_wr_addr = ctl.ld_left ? {bank_reg, ld_idx} : {~bank_reg, res_idx};
        left_wr_data = ctl.ld_left ? ld_data : res_data;
        left_rd_addr = {bank_reg, left_rd_idx};
    end

    always_ff @(posedge aclk) begin
        if (left_we) begin
            left_mem[left_wr_addr] <= left_wr_data;
        end
        if (ctl.ld_right) begin
            right_mem[ld_idx] <= ld_data;
        end
        if (ctl.rd_en) begin
            left_q_reg   <= left_mem[left_rd_addr];
            right_q_reg  <= right_mem[right_rd_idx];
            left_qv_reg  <= left_vld_reg[left_rd_addr];
            right_qv_reg <= right_vld_reg[right_rd_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_vld_reg  <= '0;
            right_vld_reg <= '0;
            bank_reg      <= 1'b0;
        end else begin
            if (left_we) begin
                left_vld_reg[left_wr_addr] <= 1'b1;
            end
            if (ctl.ld_right) begin
                right_vld_reg[ld_idx] <= 1'b1;
            end
            if (ctl.swap) begin
                bank_reg <= ~bank_reg;
            end
        end
    end

    assign left_rd_data  = left_qv_reg  ? left_q_reg  : '0;
    assign right_rd_data = right_qv_reg ? right_q_reg : '0;

endmodule

`default_nettype wire

// ----- src/matx_mac.sv -----
// ----------------------------------------------------------------------------
// matx_mac
// Shared multiply-accumulate unit: one signed 32x32 product or one sum or
// difference per cycle, accumulated exactly; products are then scaled, every result saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module matx_mac (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire matx_pkg::mac_ctl_t                  ctl,
    input  wire matx_pkg::cmd_t                      op,
    input  wire logic signed [matx_pkg::VAL_W-1:0]   a_in,
    input  wire logic signed [matx_pkg::VAL_W-1:0]   b_in,
    output logic                                     done,
    output logic signed [matx_pkg::VAL_W-1:0]        result
);

    localparam int ACC_W = matx_pkg::ACC_W;
    localparam int VAL_W = matx_pkg::VAL_W;

    logic signed [63:0]      prod;
    logic signed [ACC_W-1:0] term_next;
    logic signed [ACC_W-1:0] term_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] a_ext;
    logic signed [ACC_W-1:0] b_ext;
    logic signed [ACC_W-1:0] scaled;
    logic                    v1_reg;
    logic                    first1_reg;
    logic                    last1_reg;
    logic                    done_reg;
    logic                    in_range;

    always_comb begin
        prod  = a_in * b_in;
        a_ext = {{(ACC_W-VAL_W){a_in[VAL_W-1]}}, a_in};
        b_ext = {{(ACC_W-VAL_W){b_in[VAL_W-1]}}, b_in};
        case (op)
            matx_pkg::CMD_MUL: term_next = {{(ACC_W-64){prod[63]}}, prod};
            matx_pkg::CMD_SUB: term_next = a_ext - b_ext;
            default:           term_next = a_ext + b_ext;
        endcase
    end

    always_ff @(posedge aclk) begin
        term_reg <= term_next;
        if (v1_reg) begin
            acc_reg <= first1_reg ? term_reg : acc_reg + term_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg     <= 1'b0;
            first1_reg <= 1'b0;
            last1_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end else begin
            v1_reg     <= ctl.valid;
            first1_reg <= ctl.first;
            last1_reg  <= ctl.last;
            done_reg   <= v1_reg & last1_reg;
        end
    end

    // arithmetic shift floors toward minus infinity
    always_comb begin
        scaled   = (op == matx_pkg::CMD_MUL) ? (acc_reg >>> matx_pkg::FRAC_BITS) : acc_reg;
        in_range = (scaled[ACC_W-1:VAL_W-1] == '0) || (scaled[ACC_W-1:VAL_W-1] == '1);
        if (in_range) begin
            result = scaled[VAL_W-1:0];
        end else if (scaled[ACC_W-1]) begin
            result = {1'b1, {(VAL_W-1){1'b0}}};
        end else begin
            result = {1'b0, {(VAL_W-1){1'b1}}};
        end
    end

    assign done = done_reg;

endmodule

`default_nettype wire

// ----- src/matrix4_multiply_add_sub.sv -----
// ----------------------------------------------------------------------------
// matrix4_multiply_add_sub
// Load: writes the element, no result. Multiply: per element MAT_DIM operand pairs
// are issued, then the mac result is awaited and emitted; add/subtract: one pair.
// Per element the single shared multiplier and the one read port of each
// matrix memory set the pace; one item is in work at a time.
// Reset clears both matrices at once through per-entry valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module matrix4_multiply_add_sub (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // elem_index[3:0], elem_value[35:4], zero[39:36]
    input  wire logic [2:0]  s_tuser,   // cmd[2:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // out_index[3:0], out_value[35:4], zero[39:36]
    output logic             m_tlast
);

    localparam int IDX_W = matx_pkg::IDX_W;
    localparam int DIM_W = matx_pkg::DIM_W;
    localparam int VAL_W = matx_pkg::VAL_W;

    matx_pkg::state_t  state_reg, state_next;
    matx_pkg::cmd_t    op_reg;
    matx_pkg::st_ctl_t st_ctl;
    matx_pkg::mac_ctl_t mac_ctl_next, mac_ctl_reg;

    logic [DIM_W-1:0] k_reg, row_reg, col_reg;
    logic [IDX_W-1:0] elem_reg;
    logic [IDX_W-1:0] left_rd_idx, right_rd_idx, ld_idx;

    logic                     s_xfer;
    logic [2:0]               in_cmd;
    logic [3:0]               in_index;
    logic signed [VAL_W-1:0]  in_value;
    logic                     is_op;
    logic                     idx_ok;
    logic                     last_issue;
    logic                     last_elem;
    logic                     emit;

    logic signed [VAL_W-1:0]  left_rd_data, right_rd_data, mac_result;
    logic                     mac_done;

    logic                     out_valid_reg;
    logic [3:0]               out_index_reg;
    logic [VAL_W-1:0]         out_value_reg;
    logic                     out_last_reg;

    assign in_cmd   = s_tuser[2:0];
    assign in_index = s_tdata[3:0];
    assign in_value = s_tdata[35:4];
    assign s_xfer   = s_tvalid & s_tready;

    assign is_op = (in_cmd == matx_pkg::CMD_MUL) || (in_cmd == matx_pkg::CMD_ADD) ||
                   (in_cmd == matx_pkg::CMD_SUB);
    assign idx_ok = {3'b000, in_index} < 7'(matx_pkg::NELEM);
    assign ld_idx = IDX_W'(in_index);

    assign last_issue = (op_reg != matx_pkg::CMD_MUL) ||
                        (k_reg == DIM_W'(matx_pkg::MAT_DIM - 1));
    assign last_elem  = (elem_reg == IDX_W'(matx_pkg::NELEM - 1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            matx_pkg::ST_IDLE: begin
                if (s_xfer && is_op) begin
                    state_next = matx_pkg::ST_ISSUE;
                end
            end
            matx_pkg::ST_ISSUE: begin
                if (last_issue) begin
                    state_next = matx_pkg::ST_WAIT;
                end
            end
            matx_pkg::ST_WAIT: begin
                if (mac_done) begin
                    state_next = matx_pkg::ST_EMIT;
                end
            end
            matx_pkg::ST_EMIT: begin
                if (!out_valid_reg || m_tready) begin
                    state_next = last_elem ? matx_pkg::ST_IDLE : matx_pkg::ST_ISSUE;
                end
            end
            default: state_next = matx_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer; ready is high in idle, so tvalid alone marks a transfer
    always_comb begin
        s_tready     = 1'b0;
        st_ctl       = '0;
        mac_ctl_next = '0;
        emit         = 1'b0;
        case (state_reg)
            matx_pkg::ST_IDLE: begin
                s_tready        = 1'b1;
                st_ctl.ld_left  = s_tvalid && idx_ok && (in_cmd == matx_pkg::CMD_LOAD_LEFT);
                st_ctl.ld_right = s_tvalid && idx_ok && (in_cmd == matx_pkg::CMD_LOAD_RIGHT);
            end
            matx_pkg::ST_ISSUE: begin
                st_ctl.rd_en       = 1'b1;
                mac_ctl_next.valid = 1'b1;
                mac_ctl_next.first = (k_reg == '0);
                mac_ctl_next.last  = last_issue;
            end
            matx_pkg::ST_EMIT: begin
                emit          = !out_valid_reg || m_tready;
                st_ctl.res_we = emit;
                st_ctl.swap   = emit && last_elem;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        if (op_reg == matx_pkg::CMD_MUL) begin
            left_rd_idx  = IDX_W'(row_reg) +
                           IDX_W'(matx_pkg::MAT_DIM) * IDX_W'(k_reg);
            right_rd_idx = IDX_W'(k_reg) +
                           IDX_W'(matx_pkg::MAT_DIM) * IDX_W'(col_reg);
        end else begin
            left_rd_idx  = elem_reg;
            right_rd_idx = elem_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= matx_pkg::ST_IDLE;
            mac_ctl_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            mac_ctl_reg <= mac_ctl_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // operation counters: k walks the inner sum, row/col/elem the result
    always_ff @(posedge aclk) begin
        if (state_reg == matx_pkg::ST_IDLE && s_xfer && is_op) begin
            op_reg   <= matx_pkg::cmd_t'(in_cmd);
            k_reg    <= '0;
            row_reg  <= '0;
            col_reg  <= '0;
            elem_reg <= '0;
        end
        if (st_ctl.rd_en) begin
            k_reg <= last_issue ? '0 : k_reg + 1'b1;
        end
        if (emit) begin
            elem_reg <= elem_reg + 1'b1;
            if (row_reg == DIM_W'(matx_pkg::MAT_DIM - 1)) begin
                row_reg <= '0;
                col_reg <= col_reg + 1'b1;
            end else begin
                row_reg <= row_reg + 1'b1;
            end
            out_index_reg <= 4'(elem_reg);
            out_value_reg <= mac_result;
            out_last_reg  <= last_elem;
        end
    end

    matx_store u_store (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ctl           (st_ctl),
        .left_rd_idx   (left_rd_idx),
        .right_rd_idx  (right_rd_idx),
        .ld_idx        (ld_idx),
        .ld_data       (in_value),
        .res_idx       (elem_reg),
        .res_data      (mac_result),
        .left_rd_data  (left_rd_data),
        .right_rd_data (right_rd_data)
    );

    matx_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl_reg),
        .op      (op_reg),
        .a_in    (left_rd_data),
        .b_in    (right_rd_data),
        .done    (mac_done),
        .result  (mac_result)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_value_reg, out_index_reg};
    assign m_tlast  = out_last_reg;

    // the mac finishes an element only while the sequencer waits for it
    `ASSERT_CLK(a_done_in_wait, aclk, aresetn,
        mac_done |-> (state_reg == matx_pkg::ST_WAIT))
    // the left bank has a single write port: loads and results never collide
    `ASSERT_CLK(a_left_port, aclk, aresetn, !(st_ctl.ld_left && st_ctl.res_we))
    // banks swap only together with the write of the final element
    `ASSERT_CLK(a_swap_last, aclk, aresetn,
        st_ctl.swap |-> (st_ctl.res_we && elem_reg == IDX_W'(matx_pkg::NELEM - 1)))
    // a marked result always carries the final position
    `ASSERT_CLK(a_last_index, aclk, aresetn,
        (m_tvalid && m_tlast) |-> (out_index_reg == 4'(matx_pkg::NELEM - 1)))

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Streams element loads and multiply/add/subtract commands into the matrix
// unit: a directed table first, then random traffic. Every result transfer
// is checked against a behavioral model of both matrices, with random idle
// and stall on both channels.
// ----------------------------------------------------------------------------

module tb_top;

    localparam int unsigned CYCLE_LIMIT = 1_000_000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RAND_ITEMS  = 205;
    localparam int unsigned DRAIN_AT    = 100;
    localparam int unsigned PRINT_MAX   = 40;

    localparam logic [2:0] CMD_RSVD_5 = 3'd5;
    localparam logic [2:0] CMD_RSVD_6 = 3'd6;
    localparam logic [2:0] CMD_RSVD_7 = 3'd7;

    localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MIN = 32'h8000_0000;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic signed [67:0] SAT_HI = 68'sd2147483647;
    localparam logic signed [67:0] SAT_LO = -68'sd2147483648;

    typedef struct {
        logic [2:0]  cmd;
        logic [3:0]  idx;
        logic [31:0] val;
        bit          fixed_exp;   // exp_val is the result at position idx
        logic [31:0] exp_val;
    } stim_row_t;

    typedef struct {
        logic [3:0]  pos;
        logic [31:0] value;
        logic        last;
    } elem_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;     // elem_index[3:0], elem_value[35:4], zero[39:36]
    logic [2:0]  s_tuser;     // cmd[2:0]
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;     // out_index[3:0], out_value[35:4], zero[39:36]
    logic        m_tlast;

    logic signed [31:0] left_mat  [matx_pkg::NELEM];
    logic signed [31:0] right_mat [matx_pkg::NELEM];
    elem_result_t       expected_elems [$];

    int unsigned err_cnt;
    int unsigned result_cnt;
    int unsigned cycle_cnt;
    bit          hold_off_req;

    stim_row_t dir_tab [25] = '{
        '{matx_pkg::CMD_SUB,        4'd0,  32'd0,         1'b1, 32'd0},  // all zero after reset
        '{matx_pkg::CMD_LOAD_LEFT,  4'd0,  Q_MAX,         1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd0,  Q_MAX,         1'b0, 32'd0},
        '{matx_pkg::CMD_ADD,        4'd0,  32'd0,         1'b1, Q_MAX},  // positive overflow
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd0,  Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_SUB,        4'd0,  32'd0,         1'b1, Q_MAX},
        '{matx_pkg::CMD_LOAD_LEFT,  4'd15, Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd15, 32'd1,         1'b0, 32'd0},
        '{matx_pkg::CMD_SUB,        4'd15, 32'd0,         1'b1, Q_MIN},  // negative overflow
        '{matx_pkg::CMD_LOAD_LEFT,  4'd0,  Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd0,  Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_MUL,        4'd0,  32'd0,         1'b1, Q_MAX},
        '{matx_pkg::CMD_LOAD_LEFT,  4'd0,  Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd0,  Q_MAX,         1'b0, 32'd0},
        '{matx_pkg::CMD_MUL,        4'd0,  32'd0,         1'b1, Q_MIN},
        '{CMD_RSVD_5,               4'd0,  32'd0,         1'b0, 32'd0},  // unused codes: no result
        '{CMD_RSVD_6,               4'd15, Q_MAX,         1'b0, 32'd0},
        '{CMD_RSVD_7,               4'd0,  Q_MIN,         1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_LEFT,  4'd0,  32'hFFFF_FFFF, 1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd0,  Q_ONE,         1'b0, 32'd0},
        '{matx_pkg::CMD_MUL,        4'd0,  32'd0,         1'b0, 32'd0},  // shift rounds down
        '{matx_pkg::CMD_LOAD_LEFT,  4'd5,  32'h0001_8000, 1'b0, 32'd0},
        '{matx_pkg::CMD_LOAD_RIGHT, 4'd10, 32'hFFFE_8000, 1'b0, 32'd0},
        '{matx_pkg::CMD_MUL,        4'd0,  32'd0,         1'b0, 32'd0},
        '{matx_pkg::CMD_ADD,        4'd0,  32'd0,         1'b0, 32'd0}
    };

    matrix4_multiply_add_sub u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // matrix model
    // ------------------------------------------------------------------
    function automatic logic [31:0] sat32(input logic signed [67:0] v);
        if (v > SAT_HI) begin
            return Q_MAX;
        end else if (v < SAT_LO) begin
            return Q_MIN;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] dot_product(input int unsigned row, input int unsigned col);
        logic signed [67:0] acc;
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] prod;
        acc = '0;
        for (int e = 0; e < matx_pkg::MAT_DIM; e++) begin
            a    = left_mat[row + matx_pkg::MAT_DIM * e];
            b    = right_mat[e + matx_pkg::MAT_DIM * col];
            prod = a * b;
            acc  = acc + prod;
        end
        // arithmetic shift floors toward minus infinity
        return sat32(acc >>> matx_pkg::FRAC_BITS);
    endfunction

    function automatic void apply_item(input logic [2:0] cmd, input logic [3:0] idx,
                                       input logic [31:0] val, input bit fixed_exp,
                                       input logic [31:0] exp_val);
        logic [31:0]        res [matx_pkg::NELEM];
        logic signed [32:0] a33;
        logic signed [32:0] b33;
        case (cmd)
            matx_pkg::CMD_LOAD_LEFT: begin
                left_mat[idx] = val;
            end
            matx_pkg::CMD_LOAD_RIGHT: begin
                right_mat[idx] = val;
            end
            matx_pkg::CMD_MUL, matx_pkg::CMD_ADD, matx_pkg::CMD_SUB: begin
                for (int i = 0; i < matx_pkg::NELEM; i++) begin
                    a33 = left_mat[i];
                    b33 = right_mat[i];
                    if (cmd == matx_pkg::CMD_MUL) begin
                        res[i] = dot_product(i % matx_pkg::MAT_DIM, i / matx_pkg::MAT_DIM);
                    end else if (cmd == matx_pkg::CMD_ADD) begin
                        res[i] = sat32(a33 + b33);
                    end else begin
                        res[i] = sat32(a33 - b33);
                    end
                end
                if (fixed_exp) begin
                    res[idx] = exp_val;
                end
                for (int i = 0; i < matx_pkg::NELEM; i++) begin
                    left_mat[i] = res[i];
                    expected_elems.push_back('{pos: i[3:0], value: res[i],
                                               last: (i == matx_pkg::NELEM - 1)});
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (err_cnt < PRINT_MAX) begin
            $display("mismatch at result %0d: %s got %h want %h", result_cnt, what, got, want);
        end
        err_cnt++;
    endtask

    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0:       v = Q_MAX;
                    1:       v = Q_MIN;
                    2:       v = 32'd0;
                    3:       v = Q_ONE;
                    4:       v = -Q_ONE;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            default: begin
                // varied magnitudes of either sign
                v = $urandom;
                v = v >>> $urandom_range(0, 24);
            end
        endcase
        return v;
    endfunction

    task automatic send_item(input logic [2:0] cmd, input logic [3:0] idx,
                             input logic [31:0] val, input bit fixed_exp,
                             input logic [31:0] exp_val, input int unsigned gap);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'b0, val, idx};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        apply_item(cmd, idx, val, fixed_exp, exp_val);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_elems.size() != 0) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        elem_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_elems.size() == 0) begin
                report_mismatch("unexpected transfer, data", m_tdata[35:4], 32'd0);
            end else begin
                want = expected_elems.pop_front();
                if (m_tdata[3:0] !== want.pos) begin
                    report_mismatch("out_index", 32'(m_tdata[3:0]), 32'(want.pos));
                end
                if (m_tdata[35:4] !== want.value) begin
                    report_mismatch("out_value", m_tdata[35:4], want.value);
                end
                if (m_tlast !== want.last) begin
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
                end
            end
            result_cnt++;
        end
    end

    // ------------------------------------------------------------------
    // result side: random ready pattern plus one long hold-off
    // ------------------------------------------------------------------
    initial begin
        int unsigned run;
        int unsigned stall;
        int unsigned hold_cnt;
        m_tready = 1'b0;
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                @(negedge aclk);
                m_tready <= 1'b0;
                hold_cnt = 0;
                while (hold_cnt < HOLD_CYCLES) begin
                    @(negedge aclk);
                    hold_cnt++;
                end
            end
            run = $urandom_range(1, 40);
            repeat (run) begin
                @(negedge aclk);
                m_tready <= 1'b1;
            end
            stall = ($urandom_range(0, 7) == 0) ? 0 : idle_len();
            if (stall > 0) begin
                @(negedge aclk);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge aclk);
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------
    initial begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("tb_top: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        int unsigned sent;
        int unsigned r;
        int unsigned gap;
        logic [2:0]  cmd;
        logic [3:0]  idx;
        logic [31:0] val;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        err_cnt      = 0;
        result_cnt   = 0;
        hold_off_req = 1'b0;
        for (int i = 0; i < matx_pkg::NELEM; i++) begin
            left_mat[i]  = '0;
            right_mat[i] = '0;
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_tab[i]) begin
            send_item(dir_tab[i].cmd, dir_tab[i].idx, dir_tab[i].val,
                      dir_tab[i].fixed_exp, dir_tab[i].exp_val, idle_len());
        end

        // receiver stalls a long while, sender keeps offering
        hold_off_req = 1'b1;
        sent = 0;
        while (sent < RAND_ITEMS) begin
            if (sent == DRAIN_AT) begin
                wait_drained();
                sent++;
            end
            r = $urandom_range(0, 99);
            if (r < 12) begin
                cmd = matx_pkg::CMD_MUL;
            end else if (r < 19) begin
                cmd = matx_pkg::CMD_ADD;
            end else if (r < 26) begin
                cmd = matx_pkg::CMD_SUB;
            end else if (r < 29) begin
                cmd = CMD_RSVD_5 + 3'($urandom_range(0, 2));
            end else begin
                cmd = $urandom_range(0, 1) ? matx_pkg::CMD_LOAD_RIGHT
                                           : matx_pkg::CMD_LOAD_LEFT;
            end
            idx = 4'($urandom_range(0, matx_pkg::NELEM - 1));
            val = pick_value();
            // a stretch of back-to-back transfers
            gap = (sent >= 40 && sent < 80) ? 0 : idle_len();
            send_item(cmd, idx, val, 1'b0, 32'd0, gap);
            if (cmd < CMD_RSVD_5) begin
                sent++;
            end
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (err_cnt == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
